[src/scu_pkg.sv]
// ----------------------------------------------------------------------------
// scu_pkg: shared types and constants of the source code tokenizer unit
// Holds the request and token structs, the scanner state, the token kind
// codes and the one- and two-byte operator tables.
// ----------------------------------------------------------------------------
package scu_pkg;

  localparam int POS_BITS  = 24;
  localparam int LINE_BITS = 24;
  localparam int KIND_BITS = 6;
  localparam int MAX_TOKS  = 4;
  localparam int CNT_BITS  = $clog2(MAX_TOKS + 1);
  localparam int IDX_BITS  = $clog2(MAX_TOKS);

  typedef logic [POS_BITS-1:0]  scu_pos_t;
  typedef logic [LINE_BITS-1:0] scu_line_t;
  typedef logic [KIND_BITS-1:0] scu_kind_t;

  localparam scu_pos_t  POS_MAX  = {POS_BITS{1'b1}};
  localparam scu_line_t LINE_MAX = {LINE_BITS{1'b1}};

  // Special bytes.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // Token kinds.
  localparam scu_kind_t K_IDENT       = 6'd0;
  localparam scu_kind_t K_NONE        = 6'd0;
  localparam scu_kind_t K_NUM         = 6'd1;
  localparam scu_kind_t K_STR         = 6'd2;
  localparam scu_kind_t K_LBRACKET    = 6'd3;
  localparam scu_kind_t K_RBRACKET    = 6'd4;
  localparam scu_kind_t K_LBRACE      = 6'd5;
  localparam scu_kind_t K_RBRACE      = 6'd6;
  localparam scu_kind_t K_LPAREN      = 6'd7;
  localparam scu_kind_t K_RPAREN      = 6'd8;
  localparam scu_kind_t K_EQ_EQ       = 6'd9;
  localparam scu_kind_t K_NOT_EQ      = 6'd10;
  localparam scu_kind_t K_NOT         = 6'd11;
  localparam scu_kind_t K_ASSIGN      = 6'd12;
  localparam scu_kind_t K_ARROW       = 6'd13;
  localparam scu_kind_t K_LESS        = 6'd14;
  localparam scu_kind_t K_GREATER     = 6'd15;
  localparam scu_kind_t K_DOT_DOT     = 6'd16;
  localparam scu_kind_t K_DOT         = 6'd17;
  localparam scu_kind_t K_SEMI        = 6'd18;
  localparam scu_kind_t K_COLON_COLON = 6'd19;
  localparam scu_kind_t K_COLON       = 6'd20;
  localparam scu_kind_t K_QUESTION    = 6'd21;
  localparam scu_kind_t K_COMMA       = 6'd22;
  localparam scu_kind_t K_PLUS_PLUS   = 6'd23;
  localparam scu_kind_t K_MINUS_MINUS = 6'd24;
  localparam scu_kind_t K_PLUS_EQ     = 6'd25;
  localparam scu_kind_t K_MINUS_EQ    = 6'd26;
  localparam scu_kind_t K_SLASH_EQ    = 6'd27;
  localparam scu_kind_t K_STAR_EQ     = 6'd28;
  localparam scu_kind_t K_PLUS        = 6'd29;
  localparam scu_kind_t K_MINUS       = 6'd30;
  localparam scu_kind_t K_SLASH       = 6'd31;
  localparam scu_kind_t K_STAR        = 6'd32;
  localparam scu_kind_t K_PERCENT     = 6'd33;
  localparam scu_kind_t K_AMP         = 6'd34;
  localparam scu_kind_t K_END         = 6'd35;
  localparam scu_kind_t K_ERR         = 6'd36;

  // Scanner modes.
  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_IDENT = 4'd1,
    MODE_NINT  = 4'd2,
    MODE_NDOT  = 4'd3,
    MODE_NFRAC = 4'd4,
    MODE_STR   = 4'd5,
    MODE_CMT   = 4'd6,
    MODE_OP    = 4'd7
  } scu_mode_t;

  // Input request: one byte and the end marker.
  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       end_of_file;
  } scu_in_t;

  // One output token.
  typedef struct packed {
    scu_kind_t token_kind;
    scu_pos_t  start_pos;
    scu_pos_t  end_pos;
    scu_line_t line_no;
    logic      is_last;
  } scu_out_t;

  // A token as stored in a bundle, before is_last is known.
  typedef struct packed {
    scu_kind_t kind;
    scu_pos_t  start_pos;
    scu_pos_t  end_pos;
    scu_line_t line_no;
  } scu_tok_t;

  // All tokens caused by one input request.
  typedef struct packed {
    scu_tok_t [MAX_TOKS-1:0] tok;
    logic [CNT_BITS-1:0]     cnt;
  } scu_bundle_t;

  // Scanner state carried from byte to byte.
  typedef struct packed {
    scu_mode_t  mode;
    logic [7:0] op_first_char;
    scu_pos_t   token_start;
    scu_line_t  token_line;
    scu_pos_t   position;
    scu_line_t  line_count;
    logic       halted;
    scu_pos_t   dot_at;
  } scu_state_t;

  localparam scu_state_t ST_RESET = '{
    mode:          MODE_IDLE,
    op_first_char: 8'd0,
    token_start:   '0,
    token_line:    LINE_BITS'(1),
    position:      '0,
    line_count:    LINE_BITS'(1),
    halted:        1'b0,
    dot_at:        '0
  };

  // Kind of a one-byte operator, K_NONE if the byte is not one.
  function automatic scu_kind_t single_kind(input logic [7:0] c);
    scu_kind_t k;
    case (c)
      "[":     k = K_LBRACKET;
      "]":     k = K_RBRACKET;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "!":     k = K_NOT;
      "=":     k = K_ASSIGN;
      "<":     k = K_LESS;
      ">":     k = K_GREATER;
      ".":     k = K_DOT;
      ";":     k = K_SEMI;
      ":":     k = K_COLON;
      "?":     k = K_QUESTION;
      ",":     k = K_COMMA;
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "/":     k = K_SLASH;
      "*":     k = K_STAR;
      "%":     k = K_PERCENT;
      "&":     k = K_AMP;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // Kind of a two-byte operator, K_NONE if the pair is not one.
  function automatic scu_kind_t pair_kind(input logic [7:0] f, input logic [7:0] c);
    scu_kind_t k;
    k = K_NONE;
    case (f)
      "=": if (c == "=") k = K_EQ_EQ;
      "!": if (c == "=") k = K_NOT_EQ;
      "-": begin
        if (c == ">") k = K_ARROW;
        else if (c == "-") k = K_MINUS_MINUS;
        else if (c == "=") k = K_MINUS_EQ;
      end
      ".": if (c == ".") k = K_DOT_DOT;
      ":": if (c == ":") k = K_COLON_COLON;
      "+": begin
        if (c == "+") k = K_PLUS_PLUS;
        else if (c == "=") k = K_PLUS_EQ;
      end
      "/": if (c == "=") k = K_SLASH_EQ;
      "*": if (c == "=") k = K_STAR_EQ;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

[src/source_code_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// source_code_tokenizer_unit: longest-match source tokenizer
// Splits a byte stream into identifiers, numbers, strings and operators,
// skipping whitespace and line comments, and reports each token's kind,
// offsets and start line.
// ----------------------------------------------------------------------------
// Usage:
//   The src channel takes one request per cycle while src_ready is high: a
//   byte (ch, when ch_valid is set) and an end_of_file flag. The tok channel
//   returns the tokens that the request produces, zero to four, in order, the
//   last one marked by is_last. A request that produces no token returns
//   nothing. With an empty queue the first token of a request passes the input
//   register, then the scanner step into the token queue, before it is
//   presented. One request per cycle is taken while each request makes at most
//   one token and the receiver keeps up; a request with several tokens holds
//   the output while the queue's output port hands them out one per cycle.
//   The queue holds two bundles, so a stalled receiver first fills the queue
//   and then src_ready drops; nothing is lost.
//   Reset clears the scanner to offset 0, line 1 and empties the queue.
//   After an end_of_file request the scanner returns to that same state.
// ----------------------------------------------------------------------------
module source_code_tokenizer_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  scu_pkg::scu_in_t  src,
  output logic              tok_valid,
  input  logic              tok_ready,
  output scu_pkg::scu_out_t tok
);

  scu_pkg::scu_in_t     src_r;
  logic                 src_full;
  scu_pkg::scu_state_t  st;
  scu_pkg::scu_state_t  st_next;
  scu_pkg::scu_bundle_t bundle;
  logic                 can_push;
  logic                 go;
  logic                 push;

  scu_step u_step (
    .st      (st),
    .item    (src_r),
    .st_next (st_next),
    .bundle  (bundle)
  );

  scu_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (bundle),
    .can_push  (can_push),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  // The held request steps once its tokens, if any, have room in the queue.
  assign go        = src_full && ((bundle.cnt == '0) || can_push);
  assign push      = go && (bundle.cnt != '0);
  assign src_ready = !src_full || go;

  // Input request register.
  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      src_r <= src;
    end
  end

  // Request occupancy and scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_full <= 1'b0;
      st       <= scu_pkg::ST_RESET;
    end else begin
      if (src_valid && src_ready) begin
        src_full <= 1'b1;
      end else if (go) begin
        src_full <= 1'b0;
      end
      if (go) begin
        st <= st_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    (go && src_r.end_of_file) |=>
      (st.mode == scu_pkg::MODE_IDLE && st.position == '0 && !st.halted))
    else $error("scanner did not restart after end of source");

  a_halt_holds_pos: assert property (@(posedge clk) disable iff (rst)
    (st.halted && !(go && src_r.end_of_file)) |=> $stable(st.position))
    else $error("offset moved while halted");
`endif

endmodule

[src/scu_step.sv]
// ----------------------------------------------------------------------------
// scu_step: one scanner transition
// From the current scanner state and one input request, computes the next
// state and the bundle of up to four tokens that the request produces.
// ----------------------------------------------------------------------------
module scu_step (
  input  scu_pkg::scu_state_t  st,
  input  scu_pkg::scu_in_t     item,
  output scu_pkg::scu_state_t  st_next,
  output scu_pkg::scu_bundle_t bundle
);

  // Character classes.
  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_head(input logic [7:0] c);
    return is_alpha(c) || c == "_" || c == "@";
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || c inside {[8'd9:8'd13]};
  endfunction

  function automatic logic can_extend(input logic [7:0] c);
    return c inside {"=", "!", "-", ".", ":", "+", "/", "*"};
  endfunction

  function automatic scu_pkg::scu_pos_t sat_pos(input scu_pkg::scu_pos_t v);
    return (v == scu_pkg::POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic scu_pkg::scu_line_t sat_line(input scu_pkg::scu_line_t v);
    return (v == scu_pkg::LINE_MAX) ? v : v + 1'b1;
  endfunction

  // Append one token to a bundle unless it is already full.
  function automatic scu_pkg::scu_bundle_t put(input scu_pkg::scu_bundle_t b,
                                               input scu_pkg::scu_kind_t k,
                                               input scu_pkg::scu_pos_t sp,
                                               input scu_pkg::scu_pos_t ep,
                                               input scu_pkg::scu_line_t ln);
    scu_pkg::scu_bundle_t r;
    r = b;
    if (b.cnt < scu_pkg::CNT_BITS'(scu_pkg::MAX_TOKS)) begin
      r.tok[b.cnt[scu_pkg::IDX_BITS-1:0]] = '{kind: k, start_pos: sp, end_pos: ep,
                                              line_no: ln};
      r.cnt = b.cnt + 1'b1;
    end
    return r;
  endfunction

  scu_pkg::scu_state_t  s;
  scu_pkg::scu_bundle_t b;
  scu_pkg::scu_kind_t   k;
  scu_pkg::scu_pos_t    p;
  logic [7:0]           c;
  logic                 start_tok;

  always_comb begin
    s         = st;
    b         = '0;
    c         = item.ch;
    p         = st.position;
    k         = scu_pkg::K_NONE;
    start_tok = 1'b0;

    // Feed one byte unless the scan has halted on an error.
    if (item.ch_valid && !st.halted) begin
      case (s.mode)
        scu_pkg::MODE_IDENT: begin
          if (!is_word(c)) begin
            b = put(b, scu_pkg::K_IDENT, s.token_start, p, s.token_line);
            start_tok = 1'b1;
          end
        end
        scu_pkg::MODE_NINT: begin
          if (c == ".") begin
            s.mode   = scu_pkg::MODE_NDOT;
            s.dot_at = p;
          end else if (!is_digit(c)) begin
            b = put(b, scu_pkg::K_NUM, s.token_start, p, s.token_line);
            start_tok = 1'b1;
          end
        end
        scu_pkg::MODE_NDOT: begin
          // The byte after the dot decides between a fraction and an operator.
          if (is_digit(c)) begin
            s.mode = scu_pkg::MODE_NFRAC;
          end else begin
            b = put(b, scu_pkg::K_NUM, s.token_start, s.dot_at, s.token_line);
            if (c == ".") begin
              b = put(b, scu_pkg::K_DOT_DOT, s.dot_at, sat_pos(p), s.line_count);
              s.mode = scu_pkg::MODE_IDLE;
            end else begin
              b = put(b, scu_pkg::K_DOT, s.dot_at, p, s.line_count);
              start_tok = 1'b1;
            end
          end
        end
        scu_pkg::MODE_NFRAC: begin
          if (!is_digit(c)) begin
            b = put(b, scu_pkg::K_NUM, s.token_start, p, s.token_line);
            start_tok = 1'b1;
          end
        end
        scu_pkg::MODE_STR: begin
          if (c == scu_pkg::CH_QUOTE) begin
            b = put(b, scu_pkg::K_STR, s.token_start, sat_pos(p), s.token_line);
            s.mode = scu_pkg::MODE_IDLE;
          end
        end
        scu_pkg::MODE_CMT: begin
          if (c == scu_pkg::CH_LF || c == scu_pkg::CH_CR) begin
            start_tok = 1'b1;
          end
        end
        scu_pkg::MODE_OP: begin
          k = scu_pkg::pair_kind(s.op_first_char, c);
          if (k != scu_pkg::K_NONE) begin
            b = put(b, k, s.token_start, sat_pos(p), s.token_line);
            s.mode = scu_pkg::MODE_IDLE;
          end else if (s.op_first_char == "/" && c == "/") begin
            s.mode = scu_pkg::MODE_CMT;
          end else begin
            b = put(b, scu_pkg::single_kind(s.op_first_char), s.token_start, p,
                    s.token_line);
            start_tok = 1'b1;
          end
        end
        default: begin
          start_tok = 1'b1;
        end
      endcase

      // Start a new token with this byte.
      if (start_tok) begin
        s.mode = scu_pkg::MODE_IDLE;
        if (!is_space(c)) begin
          s.token_start = p;
          s.token_line  = s.line_count;
          if (is_head(c)) begin
            s.mode = scu_pkg::MODE_IDENT;
          end else if (is_digit(c)) begin
            s.mode = scu_pkg::MODE_NINT;
          end else if (c == scu_pkg::CH_QUOTE) begin
            s.mode = scu_pkg::MODE_STR;
          end else if (can_extend(c)) begin
            s.mode          = scu_pkg::MODE_OP;
            s.op_first_char = c;
          end else if (scu_pkg::single_kind(c) != scu_pkg::K_NONE) begin
            b = put(b, scu_pkg::single_kind(c), p, sat_pos(p), s.line_count);
          end else begin
            b = put(b, scu_pkg::K_ERR, p, p, s.line_count);
            s.halted = 1'b1;
          end
        end
      end

      // Advance offset and line unless this byte was an error.
      if (!s.halted) begin
        s.position = sat_pos(p);
        if (c == scu_pkg::CH_LF) begin
          s.line_count = sat_line(s.line_count);
        end
      end
    end

    // End of source: emit the pending token or an error, then END; start over.
    if (item.end_of_file) begin
      if (s.halted) begin
        b = put(b, scu_pkg::K_END, s.position, s.position, s.line_count);
      end else if (s.mode == scu_pkg::MODE_STR) begin
        b = put(b, scu_pkg::K_ERR, s.token_start, s.token_start, s.token_line);
        b = put(b, scu_pkg::K_END, s.token_start, s.token_start, s.token_line);
      end else begin
        case (s.mode)
          scu_pkg::MODE_IDENT: begin
            b = put(b, scu_pkg::K_IDENT, s.token_start, s.position, s.token_line);
          end
          scu_pkg::MODE_NINT, scu_pkg::MODE_NFRAC: begin
            b = put(b, scu_pkg::K_NUM, s.token_start, s.position, s.token_line);
          end
          scu_pkg::MODE_NDOT: begin
            b = put(b, scu_pkg::K_NUM, s.token_start, s.dot_at, s.token_line);
            b = put(b, scu_pkg::K_DOT, s.dot_at, s.position, s.line_count);
          end
          scu_pkg::MODE_OP: begin
            b = put(b, scu_pkg::single_kind(s.op_first_char), s.token_start,
                    s.position, s.token_line);
          end
          default: begin
          end
        endcase
        b = put(b, scu_pkg::K_END, s.position, s.position, s.line_count);
      end
      s = scu_pkg::ST_RESET;
    end

    st_next = s;
    bundle  = b;
  end

endmodule

[src/scu_outq.sv]
// ----------------------------------------------------------------------------
// scu_outq: token bundle queue and serializer
// Holds up to two token bundles and hands their tokens out one per cycle while
// tok_ready is high, marking the last token of each bundle.
// ----------------------------------------------------------------------------
module scu_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  scu_pkg::scu_bundle_t push_data,
  output logic                 can_push,
  output logic                 tok_valid,
  input  logic                 tok_ready,
  output scu_pkg::scu_out_t    tok
);

  scu_pkg::scu_bundle_t          slot [2];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [1:0]                    used;
  logic [scu_pkg::IDX_BITS-1:0]  idx;
  scu_pkg::scu_bundle_t          head;
  scu_pkg::scu_tok_t             cur;
  logic                          last;
  logic                          pop_tok;
  logic                          pop_bundle;

  // Head token and its last mark.
  assign head       = slot[rd_ptr];
  assign cur        = head.tok[idx];
  assign last       = ({1'b0, idx} == head.cnt - 1'b1);
  assign tok_valid  = (used != 2'd0);
  assign can_push   = (used != 2'd2);
  assign pop_tok    = tok_valid && tok_ready;
  assign pop_bundle = pop_tok && last;

  assign tok = '{token_kind: cur.kind, start_pos: cur.start_pos, end_pos: cur.end_pos,
                 line_no: cur.line_no, is_last: last};

  // Bundle storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Pointers, fill level and position within the head bundle.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
      idx    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_tok) begin
        if (last) begin
          idx    <= '0;
          rd_ptr <= ~rd_ptr;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      case ({push, pop_bundle})
        2'b10:   used <= used + 2'd1;
        2'b01:   used <= used - 2'd1;
        default: used <= used;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> can_push)
    else $error("bundle pushed into a full queue");

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_data.cnt != '0))
    else $error("empty bundle pushed");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> ({1'b0, idx} < head.cnt))
    else $error("token index past the end of its bundle");
`endif

endmodule
